@@ hw/rtl/mpd_pkg.sv @@
// mpd_pkg: shared constants, types and small tables for the moon phase pipeline
// no dependencies; imported by every mpd module and the top level

package mpd_pkg;

	// defaults for the top level parameters
	localparam int FRAC_BITS_DEF = 16;
	localparam int CYCLE_Q16_DEF = 1935317;

	// port widths
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int CD_W    = 5;
	localparam int LIT_W   = 15;
	localparam int CODE_W  = 3;
	localparam int RGB_W   = 24;

	// day count relative to the epoch, biased to stay non-negative
	localparam int DN_W = 23;
	localparam longint EPOCH_DAYS = 2451550;
	localparam longint JDN_OFFSET = 32045;
	localparam longint DAY_OFFSET = 64'sd1 <<< 20;
	localparam longint JD_BIAS    = JDN_OFFSET + EPOCH_DAYS - DAY_OFFSET;
	localparam int YEAR_BASE  = 4800;
	localparam int DAYS_YEAR  = 365;
	localparam int Y_W        = 15;
	localparam int SUM_W      = 24;

	// y/100 and y/400 by reciprocal multiply, exact for y below 2^15
	localparam int DIV_M     = 20972;
	localparam int DIV_M_W   = 15;
	localparam int DIV100_SH = 21;
	localparam int DIV400_SH = 23;
	localparam int Q100_W    = Y_W + DIV_M_W - DIV100_SH;
	localparam int Q400_W    = Y_W + DIV_M_W - DIV400_SH;

	// cycle quotient estimate
	localparam int QE_W     = 19;
	localparam int RECIP_W  = 28;
	localparam int RECIP_SH = DN_W + RECIP_W - QE_W;

	// illumination scaling
	localparam longint ILLUM_SCALE  = 51200;
	localparam int     ILL_M_W      = 29;
	localparam int     ILL_SH_EXTRA = 18;
	localparam int     LIT_BAND1    = 25 * 256;
	localparam int     LIT_BAND2    = 50 * 256;
	localparam int     LIT_BAND3    = 75 * 256;

	localparam logic [RGB_W-1:0] RGB_DARK   = 24'h1A1A2E;
	localparam logic [RGB_W-1:0] RGB_DIM    = 24'h4A4A5E;
	localparam logic [RGB_W-1:0] RGB_BRIGHT = 24'hC0C0C0;
	localparam logic [RGB_W-1:0] RGB_FULL   = 24'hFFFFAA;

	localparam int FULL_NEAR  = 15;
	localparam int FULL_FAR   = 45;
	localparam int CYCLE_DAYS = 30;

	// register stages from start to done
	localparam int PIPE_DEPTH = 9;

	typedef enum logic [CODE_W-1:0] {
		PH_NEW       = 3'd0,
		PH_WAX_CRES  = 3'd1,
		PH_FIRST_QTR = 3'd2,
		PH_WAX_GIBB  = 3'd3,
		PH_FULL      = 3'd4,
		PH_WANE_GIBB = 3'd5,
		PH_LAST_QTR  = 3'd6,
		PH_WANE_CRES = 3'd7
	} phase_code_t;

	// (153*m + 2)/5 with m = month + 12a - 3, indexed by raw month
	function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] month);
		logic [8:0] v;
		case (month)
			4'd0:    v = 9'd275;
			4'd1:    v = 9'd306;
			4'd2:    v = 9'd337;
			4'd3:    v = 9'd0;
			4'd4:    v = 9'd31;
			4'd5:    v = 9'd61;
			4'd6:    v = 9'd92;
			4'd7:    v = 9'd122;
			4'd8:    v = 9'd153;
			4'd9:    v = 9'd184;
			4'd10:   v = 9'd214;
			4'd11:   v = 9'd245;
			4'd12:   v = 9'd275;
			4'd13:   v = 9'd306;
			4'd14:   v = 9'd337;
			default: v = 9'd367;
		endcase
		return v;
	endfunction

	// cycle length in the working fixed point format
	function automatic longint cycle_fixed(input int frac, input longint len_q16);
		longint c;
		c = len_q16;
		if (frac >= 16) begin
			return c <<< (frac - 16);
		end
		return (c + (64'sd1 <<< (15 - frac))) >>> (16 - frac);
	endfunction

endpackage

@@ hw/rtl/mpd_jdn.sv @@
// mpd_jdn: two stage julian day number, biased to a non-negative day count
// depends on mpd_pkg

module mpd_jdn
	import mpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic               out_valid,
	output logic [DN_W-1:0]    dn
);

	logic                           jan_feb;
	logic [Y_W-1:0]                 y;
	logic [Y_W+DIV_M_W-1:0]         p100;
	logic [Y_W+DIV_M_W-1:0]         p400;

	logic                           v_s1;
	logic                           v_s2;
	logic [Y_W-1:0]                 y_s1;
	logic [8:0]                     mt_s1;
	logic [DAY_W-1:0]               day_s1;
	logic [Q100_W-1:0]              q100_s1;
	logic [Q400_W-1:0]              q400_s1;
	logic [SUM_W-1:0]               sum;
	logic [SUM_W-1:0]               dn_full;
	logic [DN_W-1:0]                dn_s2;

	assign jan_feb = (month <= 4'd2);
	assign y       = Y_W'(year) + Y_W'(YEAR_BASE) - Y_W'(jan_feb);
	assign p100    = y * DIV_M_W'(DIV_M);
	assign p400    = y * DIV_M_W'(DIV_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		y_s1    <= y;
		mt_s1   <= month_offset(month);
		day_s1  <= day;
		q100_s1 <= p100[DIV100_SH +: Q100_W];
		q400_s1 <= p400[DIV400_SH +: Q400_W];
	end

	assign sum = SUM_W'(y_s1) * SUM_W'(DAYS_YEAR) + SUM_W'(y_s1[Y_W-1:2])
		+ SUM_W'(q400_s1) + SUM_W'(mt_s1) + SUM_W'(day_s1);
	assign dn_full = sum - SUM_W'(q100_s1) - SUM_W'(JD_BIAS);

	always_ff @(posedge clk) begin
		dn_s2 <= dn_full[DN_W-1:0];
	end

	assign out_valid = v_s2;
	assign dn        = dn_s2;

endmodule

@@ hw/rtl/mpd_phase.sv @@
// mpd_phase: three stage floored modulo of the day count against the lunar cycle
// depends on mpd_pkg; quotient by reciprocal multiply, then a two step correction

module mpd_phase
	import mpd_pkg::*;
#(
	parameter int FRAC_BITS        = FRAC_BITS_DEF,
	parameter int CYCLE_LENGTH_Q16 = CYCLE_Q16_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [DN_W-1:0]      dn,
	output logic                 out_valid,
	output logic [FRAC_BITS+4:0] phase
);

	localparam int PW = FRAC_BITS + 5;
	localparam int XW = PW + QE_W;
	localparam int RW = FRAC_BITS + 7;
	localparam longint ONE        = 64'sd1 <<< FRAC_BITS;
	localparam longint CYC        = cycle_fixed(FRAC_BITS, longint'(CYCLE_LENGTH_Q16));
	localparam longint EPOCH_FRAC = (ONE + 5) / 10;
	localparam longint BIAS       = EPOCH_FRAC + DAY_OFFSET * ONE;
	localparam longint BIAS_MOD   = BIAS % CYC;
	localparam longint CORR       = (BIAS_MOD == 0) ? 64'sd0 : CYC - BIAS_MOD;
	localparam longint RECIP      = (ONE <<< RECIP_SH) / CYC;
	localparam logic [PW-1:0]      CYC_V   = PW'(CYC);
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

	logic                      v_s3;
	logic                      v_s4;
	logic                      v_s5;
	logic [DN_W+RECIP_W-1:0]   prod;
	logic [QE_W-1:0]           qe_s3;
	logic [DN_W-1:0]           dn_s3;
	logic [XW-1:0]             x;
	logic [XW-1:0]             qc;
	logic [XW-1:0]             diff;
	logic [RW-1:0]             r_s4;
	logic [RW-1:0]             r1;
	logic [RW-1:0]             r2;
	logic [PW-1:0]             phase_n;
	logic [PW-1:0]             phase_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// quotient estimate, low by at most two lunar cycles
	assign prod = dn * RECIP_V;

	// remainder lands in [0, 3*cycle)
	assign x    = XW'({dn_s3, {FRAC_BITS{1'b0}}}) + XW'(CORR);
	assign qc   = qe_s3 * CYC_V;
	assign diff = x - qc;

	assign r1 = r_s4 - RW'(CYC);
	assign r2 = r_s4 - RW'(2 * CYC);

	always_comb begin
		if (r_s4 >= RW'(2 * CYC)) begin
			phase_n = r2[PW-1:0];
		end else if (r_s4 >= RW'(CYC)) begin
			phase_n = r1[PW-1:0];
		end else begin
			phase_n = r_s4[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		qe_s3    <= prod[DN_W+RECIP_W-1 -: QE_W];
		dn_s3    <= dn;
		r_s4     <= diff[RW-1:0];
		phase_s5 <= phase_n;
	end

	assign out_valid = v_s5;
	assign phase     = phase_s5;

endmodule

@@ hw/rtl/mpd_report.sv @@
// mpd_report: four stage derivation of cycle day, illumination, phase code, days to full and new moon, and colour
// depends on mpd_pkg; illumination quotient by reciprocal multiply with correction

module mpd_report
	import mpd_pkg::*;
#(
	parameter int FRAC_BITS        = FRAC_BITS_DEF,
	parameter int CYCLE_LENGTH_Q16 = CYCLE_Q16_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [FRAC_BITS+4:0] phase,
	output logic                 out_valid,
	output logic [CD_W-1:0]      cycle_day,
	output logic [LIT_W-1:0]     lit_fraction,
	output logic [CODE_W-1:0]    phase_code,
	output logic [CD_W-1:0]      days_until_full,
	output logic [CD_W-1:0]      days_until_new,
	output logic [RGB_W-1:0]     display_rgb
);

	localparam int PW  = FRAC_BITS + 5;
	localparam int NW  = FRAC_BITS + 4;
	localparam int TW  = FRAC_BITS + 21;
	localparam int RMW = FRAC_BITS + 7;
	localparam longint ONE      = 64'sd1 <<< FRAC_BITS;
	localparam longint CYC      = cycle_fixed(FRAC_BITS, longint'(CYCLE_LENGTH_Q16));
	localparam longint HALF     = ONE >>> 1;
	localparam longint HALF_CYC = CYC / 2;
	localparam longint ILL_M    = ((ONE <<< ILL_SH_EXTRA) * ILLUM_SCALE) / CYC;
	localparam logic [PW-1:0]      CYC_V   = PW'(CYC);
	localparam logic [ILL_M_W-1:0] ILL_M_V = ILL_M_W'(ILL_M);

	logic                      v_s6;
	logic                      v_s7;
	logic                      v_s8;
	logic                      v_s9;

	logic [PW:0]               rnd;
	logic [PW:0]               twice;
	logic [PW-1:0]             mirror;
	logic [NW-1:0]             num_n;
	logic [CD_W-1:0]           cd_s6;
	logic [NW-1:0]             num_s6;

	logic [NW+ILL_M_W-1:0]     pm;
	logic [TW-1:0]             t_n;
	logic [CD_W-1:0]           cd_s7;
	logic [LIT_W-1:0]          le_s7;
	logic [TW-1:0]             t_s7;

	logic [LIT_W+PW-1:0]       lc;
	logic [TW-1:0]             rem;
	logic [CD_W-1:0]           cd_s8;
	logic [LIT_W-1:0]          le_s8;
	logic [RMW-1:0]            rem_s8;

	logic [LIT_W-1:0]          lit_n;
	logic [CD_W-1:0]           full_n;
	logic [RGB_W-1:0]          rgb_n;
	phase_code_t               code_n;

	logic [CD_W-1:0]           cd_s9;
	logic [LIT_W-1:0]          lit_s9;
	logic [CODE_W-1:0]         code_s9;
	logic [CD_W-1:0]           full_s9;
	logic [CD_W-1:0]           new_s9;
	logic [RGB_W-1:0]          rgb_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s6 <= in_valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// round to whole days, fold the second half of the cycle back
	assign rnd    = (PW+1)'(phase) + (PW+1)'(HALF);
	assign twice  = {phase, 1'b0};
	assign mirror = CYC_V - phase;
	assign num_n  = (twice <= (PW+1)'(CYC)) ? phase[NW-1:0] : mirror[NW-1:0];

	// estimate is at most two below the rounded quotient
	assign pm  = num_s6 * ILL_M_V;
	assign t_n = TW'(num_s6) * TW'(ILLUM_SCALE) + TW'(HALF_CYC);

	assign lc  = le_s7 * CYC_V;
	assign rem = t_s7 - TW'(lc);

	assign lit_n = le_s8 + LIT_W'(rem_s8 >= RMW'(CYC)) + LIT_W'(rem_s8 >= RMW'(2 * CYC));

	assign full_n = (cd_s8 < CD_W'(FULL_NEAR)) ? CD_W'(FULL_NEAR) - cd_s8
		: CD_W'(FULL_FAR) - cd_s8;

	always_comb begin
		case (cd_s8) inside
			[5'd0:5'd1], [5'd29:5'd31]: code_n = PH_NEW;
			[5'd2:5'd6]:                code_n = PH_WAX_CRES;
			[5'd7:5'd8]:                code_n = PH_FIRST_QTR;
			[5'd9:5'd13]:               code_n = PH_WAX_GIBB;
			[5'd14:5'd16]:              code_n = PH_FULL;
			[5'd17:5'd21]:              code_n = PH_WANE_GIBB;
			[5'd22:5'd23]:              code_n = PH_LAST_QTR;
			default:                    code_n = PH_WANE_CRES;
		endcase
	end

	always_comb begin
		if (lit_n < LIT_W'(LIT_BAND1)) begin
			rgb_n = RGB_DARK;
		end else if (lit_n < LIT_W'(LIT_BAND2)) begin
			rgb_n = RGB_DIM;
		end else if (lit_n < LIT_W'(LIT_BAND3)) begin
			rgb_n = RGB_BRIGHT;
		end else begin
			rgb_n = RGB_FULL;
		end
	end

	always_ff @(posedge clk) begin
		cd_s6   <= rnd[FRAC_BITS +: CD_W];
		num_s6  <= num_n;
		cd_s7   <= cd_s6;
		le_s7   <= pm[NW+ILL_M_W-1 -: LIT_W];
		t_s7    <= t_n;
		cd_s8   <= cd_s7;
		le_s8   <= le_s7;
		rem_s8  <= rem[RMW-1:0];
		cd_s9   <= cd_s8;
		lit_s9  <= lit_n;
		code_s9 <= code_n;
		full_s9 <= full_n;
		new_s9  <= CD_W'(CYCLE_DAYS) - cd_s8;
		rgb_s9  <= rgb_n;
	end

	assign out_valid       = v_s9;
	assign cycle_day       = cd_s9;
	assign lit_fraction    = lit_s9;
	assign phase_code      = code_s9;
	assign days_until_full = full_s9;
	assign days_until_new  = new_s9;
	assign display_rgb     = rgb_s9;

endmodule

@@ hw/rtl/moon_phase_from_date.sv @@
// moon_phase_from_date: date to lunar phase, nine stage pipeline
// done is start carried through the valid register of every stage; one word per cycle, every cycle
// the rate is set by the pipeline itself: every stage holds at most two multipliers
// busy is always low since the result side cannot stall and nothing is shared
// reset (arst_n low) clears all valid bits at once; no clearing pass, data regs unreset
// depends on mpd_pkg, mpd_jdn, mpd_phase, mpd_report

module moon_phase_from_date
	import mpd_pkg::*;
#(
	parameter int FRAC_BITS        = FRAC_BITS_DEF,
	parameter int CYCLE_LENGTH_Q16 = CYCLE_Q16_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic               done,
	output logic [CD_W-1:0]    cycle_day,
	output logic [LIT_W-1:0]   lit_fraction,
	output logic [CODE_W-1:0]  phase_code,
	output logic [CD_W-1:0]    days_until_full,
	output logic [CD_W-1:0]    days_until_new,
	output logic [RGB_W-1:0]   display_rgb
);

	logic                 accept;
	logic                 dn_valid;
	logic [DN_W-1:0]      dn;
	logic                 ph_valid;
	logic [FRAC_BITS+4:0] phase;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	mpd_jdn u_jdn (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.year      (year),
		.month     (month),
		.day       (day),
		.out_valid (dn_valid),
		.dn        (dn)
	);

	mpd_phase #(
		.FRAC_BITS        (FRAC_BITS),
		.CYCLE_LENGTH_Q16 (CYCLE_LENGTH_Q16)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dn_valid),
		.dn        (dn),
		.out_valid (ph_valid),
		.phase     (phase)
	);

	mpd_report #(
		.FRAC_BITS        (FRAC_BITS),
		.CYCLE_LENGTH_Q16 (CYCLE_LENGTH_Q16)
	) u_report (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (ph_valid),
		.phase           (phase),
		.out_valid       (done),
		.cycle_day       (cycle_day),
		.lit_fraction    (lit_fraction),
		.phase_code      (phase_code),
		.days_until_full (days_until_full),
		.days_until_new  (days_until_new),
		.display_rgb     (display_rgb)
	);

endmodule

@@ hw/rtl/mpd_checker.sv @@
// mpd_checker: port level checks on moon_phase_from_date, attached by bind
// depends on mpd_pkg and moon_phase_from_date

module mpd_checker
	import mpd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [CD_W-1:0]  cycle_day,
	input logic [LIT_W-1:0] lit_fraction,
	input logic [CD_W-1:0]  days_until_new
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_DEPTH done)
		else $error("accepted word did not come out");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##PIPE_DEPTH !done)
		else $error("result without a word");

	a_new_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((6'(days_until_new) + 6'(cycle_day)) == 6'(CYCLE_DAYS)))
		else $error("days to new moon inconsistent with cycle day");

	a_lit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (lit_fraction <= LIT_W'(2 * LIT_BAND2)))
		else $error("illumination above full");

endmodule

bind moon_phase_from_date mpd_checker u_mpd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.cycle_day      (cycle_day),
	.lit_fraction   (lit_fraction),
	.days_until_new (days_until_new)
);

@@ tb/sv/testbench.sv @@
// testbench for moon_phase_from_date: drives dates through the start/busy port and
// checks every done word against a behavioral predictor held in a small scoreboard class
// depends on mpd_pkg and the moon_phase_from_date rtl
`timescale 1ns / 100ps

module testbench;
	import mpd_pkg::*;

	localparam int     FRAC      = FRAC_BITS_DEF;
	localparam longint ONE_Q     = 64'sd1 <<< FRAC;
	localparam longint LUNATION_Q = (FRAC >= 16) ?
		(longint'(CYCLE_Q16_DEF) <<< (FRAC - 16)) :
		((longint'(CYCLE_Q16_DEF) + (64'sd1 <<< (15 - FRAC))) >>> (16 - FRAC));
	localparam longint REF_NEW_MOON_Q = 64'sd2451550 * ONE_Q + (ONE_Q + 5) / 10;

	localparam logic [23:0] SHADE_DARK   = 24'h1A1A2E;
	localparam logic [23:0] SHADE_DIM    = 24'h4A4A5E;
	localparam logic [23:0] SHADE_BRIGHT = 24'hC0C0C0;
	localparam logic [23:0] SHADE_FULL   = 24'hFFFFAA;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [CD_W-1:0]    cycle_day;
		logic [LIT_W-1:0]   lit;
		phase_code_t        code;
		logic [CD_W-1:0]    to_full;
		logic [CD_W-1:0]    to_new;
		logic [RGB_W-1:0]   rgb;
	} moon_word_t;

	class phase_scoreboard;
		moon_word_t expected_moons[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected_moons.size();
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		// predict the word for one accepted date
		function void note_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
				input logic [DAY_W-1:0] d);
			moon_word_t w;
			longint jan_feb, yy, mm, jdn, since, pos, cd, fold, lit;
			jan_feb = (m <= 2) ? 1 : 0;
			yy = longint'(y) + 4800 - jan_feb;
			mm = longint'(m) + 12 * jan_feb - 3;
			jdn = longint'(d) + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400
				- 32045;
			since = jdn * ONE_Q - REF_NEW_MOON_Q;
			pos = since % LUNATION_Q;
			// floored modulo for dates before the reference new moon
			if (pos < 0) begin
				pos += LUNATION_Q;
			end
			cd = (pos + (ONE_Q >>> 1)) >>> FRAC;
			fold = (2 * pos <= LUNATION_Q) ? pos : (LUNATION_Q - pos);
			lit = (fold * 51200 + LUNATION_Q / 2) / LUNATION_Q;
			w.year = y;
			w.month = m;
			w.day = d;
			w.cycle_day = cd[CD_W-1:0];
			w.lit = lit[LIT_W-1:0];
			if (cd <= 1 || cd >= 29) w.code = PH_NEW;
			else if (cd <= 6) w.code = PH_WAX_CRES;
			else if (cd <= 8) w.code = PH_FIRST_QTR;
			else if (cd <= 13) w.code = PH_WAX_GIBB;
			else if (cd <= 16) w.code = PH_FULL;
			else if (cd <= 21) w.code = PH_WANE_GIBB;
			else if (cd <= 23) w.code = PH_LAST_QTR;
			else w.code = PH_WANE_CRES;
			w.to_full = (cd < 15) ? CD_W'(15 - cd) : CD_W'(45 - cd);
			w.to_new = CD_W'(30 - cd);
			if (lit < 25 * 256) w.rgb = SHADE_DARK;
			else if (lit < 50 * 256) w.rgb = SHADE_DIM;
			else if (lit < 75 * 256) w.rgb = SHADE_BRIGHT;
			else w.rgb = SHADE_FULL;
			expected_moons.push_back(w);
		endfunction

		task check_result(input logic [CD_W-1:0] cd, input logic [LIT_W-1:0] lit,
				input logic [CODE_W-1:0] code, input logic [CD_W-1:0] to_full,
				input logic [CD_W-1:0] to_new, input logic [RGB_W-1:0] rgb);
			moon_word_t w;
			string dt;
			if (expected_moons.size() == 0) begin
				report_mismatch("done word with no date pending");
				return;
			end
			w = expected_moons.pop_front();
			dt = $sformatf("%0d-%0d-%0d", w.year, w.month, w.day);
			if (cd !== w.cycle_day)
				report_mismatch($sformatf("%s cycle_day %0d want %0d", dt, cd, w.cycle_day));
			if (lit !== w.lit)
				report_mismatch($sformatf("%s lit_fraction %0d want %0d", dt, lit, w.lit));
			if (code !== w.code)
				report_mismatch($sformatf("%s phase_code %0d want %0d", dt, code, w.code));
			if (to_full !== w.to_full)
				report_mismatch($sformatf("%s days_until_full %0d want %0d", dt, to_full,
					w.to_full));
			if (to_new !== w.to_new)
				report_mismatch($sformatf("%s days_until_new %0d want %0d", dt, to_new,
					w.to_new));
			if (rgb !== w.rgb)
				report_mismatch($sformatf("%s display_rgb %h want %h", dt, rgb, w.rgb));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [YEAR_W-1:0]  year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic [DAY_W-1:0]   day = '0;
	logic               busy;
	logic               done;
	logic [CD_W-1:0]    cycle_day;
	logic [LIT_W-1:0]   lit_fraction;
	logic [CODE_W-1:0]  phase_code;
	logic [CD_W-1:0]    days_until_full;
	logic [CD_W-1:0]    days_until_new;
	logic [RGB_W-1:0]   display_rgb;

	phase_scoreboard moons = new();
	int cycle_count = 0;

	moon_phase_from_date DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.year            (year),
		.month           (month),
		.day             (day),
		.done            (done),
		.cycle_day       (cycle_day),
		.lit_fraction    (lit_fraction),
		.phase_code      (phase_code),
		.days_until_full (days_until_full),
		.days_until_new  (days_until_new),
		.display_rgb     (display_rgb)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// the receiver cannot stall, so every done cycle carries one word
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			moons.check_result(cycle_day, lit_fraction, phase_code, days_until_full,
				days_until_new, display_rgb);
		end
	end

	// present one date and hold it until the block takes it
	task send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic [DAY_W-1:0] d);
		year <= y;
		month <= m;
		day <= d;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		moons.note_date(y, m, d);
	endtask

	task drain_moons();
		start <= 1'b0;
		do @(posedge clk); while (moons.pending() != 0);
	endtask

	initial begin
		int yr, mo, dy, mdays, idle_pct, calm, ph, n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed dates
		send_date(14'd2000, 4'd1, 5'd6);     // reference new moon
		send_date(14'd2000, 4'd1, 5'd5);
		send_date(14'd2000, 4'd1, 5'd7);
		send_date(14'd2000, 4'd1, 5'd13);
		send_date(14'd2000, 4'd1, 5'd21);    // near full
		send_date(14'd2000, 4'd1, 5'd28);
		send_date(14'd1999, 4'd12, 5'd31);   // before the epoch
		send_date(14'd1, 4'd1, 5'd1);
		send_date(14'd9999, 4'd12, 5'd31);
		send_date(14'd16383, 4'd15, 5'd31);  // every input bit set
		send_date(14'd0, 4'd0, 5'd0);        // every input bit clear
		send_date(14'd2024, 4'd0, 5'd15);    // month zero
		send_date(14'd2024, 4'd13, 5'd1);
		send_date(14'd2024, 4'd14, 5'd10);
		send_date(14'd2024, 4'd15, 5'd31);
		send_date(14'd2024, 4'd2, 5'd0);     // day zero
		send_date(14'd2023, 4'd2, 5'd31);    // past month end
		send_date(14'd2024, 4'd2, 5'd29);
		send_date(14'd1582, 4'd10, 5'd15);
		send_date(14'd2024, 4'd3, 5'd10);
		send_date(14'd2024, 4'd3, 5'd25);
		send_date(14'd16383, 4'd0, 5'd0);
		send_date(14'd0, 4'd15, 5'd31);
		drain_moons();

		calm = 0;
		for (ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 31 : (ph == 1) ? 54 : 0;
			for (n = 0; n < 650; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					yr = $urandom_range(1, 9999);
					mo = $urandom_range(1, 12);
					case (mo)
						2: mdays = ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 29 : 28;
						4, 6, 9, 11: mdays = 30;
						default: mdays = 31;
					endcase
					dy = $urandom_range(1, mdays);
				end else begin
					yr = $urandom_range(0, 16383);
					mo = $urandom_range(0, 15);
					dy = $urandom_range(0, 31);
				end
				send_date(yr[YEAR_W-1:0], mo[MONTH_W-1:0], dy[DAY_W-1:0]);
				if (calm > 0) begin
					calm--;
				end else if ($urandom_range(0, 299) == 0) begin
					drain_moons();
				end else if ($urandom_range(0, 99) < idle_pct) begin
					// each idle cycle repeats with the same odds
					start <= 1'b0;
					do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
				end else if ($urandom_range(0, 99) < 2) begin
					calm = $urandom_range(10, 40);
				end
			end
			// let the pipe empty completely between phases
			drain_moons();
		end

		drain_moons();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (moons.errors == 0 && moons.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_jdn.sv
hw/rtl/mpd_phase.sv
hw/rtl/mpd_report.sv
hw/rtl/moon_phase_from_date.sv
hw/rtl/mpd_checker.sv
tb/sv/testbench.sv
